/* rtl/core/wmrs_pkg.sv */
// Shared types and constants for the wireless module reply sniffer.
// Used by wmrs_tracker and wifi_module_reply_sniffer_core; no dependencies.
package wmrs_pkg;

   // Window length in bytes and the largest number of emitted bytes per message
   localparam int WINDOW  = 150;
   localparam int MSG_MAX = 20;

   localparam int ByteW    = 8;
   localparam int WinPosW  = 8;
   localparam int MsgPosW  = $clog2(MSG_MAX + 1);
   localparam int MsgIdxW  = 5;

   // Packed output word widths
   localparam int RspDataW = 16;
   localparam int RspUserW = 2;

   // One result word, as it leaves the tracker
   typedef struct packed {
      logic               reply_seen;
      logic               connected;
      logic               msg_valid;
      logic [ByteW-1:0]   msg_byte;
      logic [MsgIdxW-1:0] msg_index;
      logic               msg_last;
      logic               msg_start;
   } result_type;

endpackage

/* rtl/core/wifi_module_reply_sniffer_core.sv */
// Top level of the wireless module reply sniffer: stream ports, mode
// register and a two-word output stage. Depends on wmrs_pkg, wmrs_tracker.

// Takes one received byte per clock on the req_ stream while req_tready is
// high and returns exactly one result word per byte on the rsp_ stream. All
// per-byte work is a single pass of compares and counters ahead of the output
// register, so the sustained rate is one byte per cycle while rsp_tready stays
// high. The output register is backed by a one-word skid stage: req_tready
// depends only on the skid flag, never on rsp_tready, and stays high until two
// results are waiting. A downstream stall still lets one more byte in; each
// word that lands in the skid stage then holds req_tready low while it drains.
// csr_we writes the mode bit (1 = command replies, 0 = message extraction);
// it should change only while no results are outstanding.
module wifi_module_reply_sniffer_core
   import wmrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // mode register
   input  logic                csr_we,
   input  logic                csr_wdata,      // command_mode
   // received bytes
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,      // [7:0] rx_byte
   // results
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,      // [0] reply_seen, [1] connected,
                                               // [9:2] msg_byte, [14:10] msg_index,
                                               // [15] zero
   output logic [RspUserW-1:0] rsp_tuser,      // [0] msg_valid, [1] msg_start
   output logic                rsp_tlast       // msg_last
);

   logic       cmd_mode_ff;
   logic       req_accept;
   logic       rsp_pop;
   result_type step_result;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_mode_ff <= 1'b1;
      end else if (csr_we) begin
         cmd_mode_ff <= csr_wdata;
      end
   end

   assign req_tready = ~skid_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign rsp_pop    = out_valid_ff & rsp_tready;

   wmrs_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .command_mode (cmd_mode_ff),
      .byte_accept  (req_accept),
      .rx_byte      (req_tdata),
      .result       (step_result)
   );

   // Output register plus skid word
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_in = step_result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff) begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Pack the result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.msg_index, out_ff.msg_byte,
                        out_ff.connected, out_ff.reply_seen};
   assign rsp_tuser  = {out_ff.msg_start, out_ff.msg_valid};
   assign rsp_tlast  = out_ff.msg_last;

   // Skid word only fills behind a held output word
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // An accepted byte into an empty stage shows up as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !out_valid_ff |=> out_valid_ff)
      else $error("accepted byte lost");

   // A reply ends the byte's handling, so no message fields go with it
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.reply_seen |->
         !out_ff.msg_valid && !out_ff.msg_start && !out_ff.msg_last)
      else $error("reply word carries message fields");

endmodule

/* rtl/core/wmrs_tracker.sv */
// Per-byte state and decode of the reply sniffer: pattern trackers, message
// length tracking and the connection flag. Depends on wmrs_pkg.
module wmrs_tracker
   import wmrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             command_mode,
   input  logic             byte_accept,
   input  logic [ByteW-1:0] rx_byte,
   output result_type       result
);

   localparam logic [ByteW-1:0] CharGt = 8'h3E;   // '>'
   localparam logic [ByteW-1:0] CharO  = 8'h4F;
   localparam logic [ByteW-1:0] CharK  = 8'h4B;
   localparam logic [ByteW-1:0] CharR  = 8'h72;   // 'r'
   localparam logic [ByteW-1:0] CharE  = 8'h65;
   localparam logic [ByteW-1:0] CharA  = 8'h61;
   localparam logic [ByteW-1:0] CharD  = 8'h64;
   localparam logic [ByteW-1:0] CharY  = 8'h79;

   localparam logic [ByteW-1:0] LinkUp0 = 8'h20;
   localparam logic [ByteW-1:0] LinkUp1 = 8'h02;
   localparam logic [ByteW-1:0] LinkDn0 = 8'h64;
   localparam logic [ByteW-1:0] LinkDn1 = 8'h01;
   localparam logic [ByteW-1:0] LinkDn2 = 8'h60;

   localparam logic [2:0]         ReadyFull = 3'd4;  // "read" seen, waiting on 'y'
   localparam logic [WinPosW-1:0] StartPos  = 8'd3;  // length byte needs position > 3

   function automatic logic [ByteW-1:0] ready_char(input logic [2:0] idx);
      case (idx)
         3'd0:    ready_char = CharR;
         3'd1:    ready_char = CharE;
         3'd2:    ready_char = CharA;
         3'd3:    ready_char = CharD;
         default: ready_char = CharY;
      endcase
   endfunction

   logic [ByteW-1:0]   hist0_ff, hist1_ff, hist2_ff;
   logic [ByteW-1:0]   hist0_in, hist1_in, hist2_in;
   logic [WinPosW-1:0] winpos_ff, winpos_in;
   logic               okp_ff, okp_in;
   logic [2:0]         rdyp_ff, rdyp_in;
   logic               okhit_ff, okhit_in;
   logic [ByteW-1:0]   remain_ff, remain_in;
   logic [MsgPosW-1:0] msgpos_ff, msgpos_in;
   logic               link_ff, link_in;

   logic               hit;
   logic               advance;
   logic               clear_win;
   logic [WinPosW:0]   winpos_sum;

   assign winpos_sum = {1'b0, winpos_ff} + {{WinPosW{1'b0}}, 1'b1};

   // Next state and result for the byte at the input
   always_comb begin
      hist0_in  = hist0_ff;
      hist1_in  = hist1_ff;
      hist2_in  = hist2_ff;
      winpos_in = winpos_ff;
      okhit_in  = okhit_ff;
      remain_in = remain_ff;
      msgpos_in = msgpos_ff;
      link_in   = link_ff;
      advance   = 1'b1;
      clear_win = 1'b0;
      result    = '0;

      // connection flag, on the bytes of the current window
      if (hist2_ff == LinkUp0 && hist1_ff == LinkUp1 && hist0_ff == '0 && rx_byte == '0) begin
         link_in = 1'b1;
      end
      if (hist1_ff == LinkDn0 && hist0_ff == LinkDn1 && rx_byte == LinkDn2) begin
         link_in = 1'b0;
      end
      result.connected = link_in;

      // text trackers
      hit = (rx_byte == CharGt) || (okp_ff && rx_byte == CharK) ||
            (rdyp_ff == ReadyFull && rx_byte == CharY);
      okp_in = (rx_byte == CharO);
      if (rdyp_ff < ReadyFull && rx_byte == ready_char(rdyp_ff)) begin
         rdyp_in = rdyp_ff + 3'd1;
      end else begin
         rdyp_in = (rx_byte == CharR) ? 3'd1 : 3'd0;
      end

      if (command_mode) begin
         if (hit || okhit_ff) begin
            result.reply_seen = 1'b1;
            advance           = 1'b0;
            clear_win         = 1'b1;
         end
      end else begin
         if (hit) begin
            okhit_in = 1'b1;
         end
         // message body byte
         if (remain_ff != '0) begin
            if (msgpos_ff < MsgPosW'(MSG_MAX)) begin
               result.msg_valid = 1'b1;
               result.msg_byte  = rx_byte;
               result.msg_index = MsgIdxW'(msgpos_ff);
               msgpos_in        = msgpos_ff + {{(MsgPosW-1){1'b0}}, 1'b1};
            end
            remain_in = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               result.msg_last = 1'b1;
            end
         end
         // length byte after two zero bytes
         if (winpos_ff > StartPos && hist1_ff == '0 && hist0_ff == '0 && rx_byte != '0) begin
            result.msg_start = 1'b1;
            remain_in        = rx_byte;
            msgpos_in        = '0;
         end
      end

      // shift history and move through the window
      if (advance) begin
         hist2_in  = hist1_ff;
         hist1_in  = hist0_ff;
         hist0_in  = rx_byte;
         winpos_in = winpos_sum[WinPosW-1:0];
         if (winpos_sum >= (WinPosW+1)'(WINDOW)) begin
            clear_win = 1'b1;
         end
      end

      if (clear_win) begin
         hist0_in  = '0;
         hist1_in  = '0;
         hist2_in  = '0;
         winpos_in = '0;
         okp_in    = 1'b0;
         rdyp_in   = 3'd0;
         okhit_in  = 1'b0;
      end
   end

   // State registers, updated on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff  <= '0;
         hist1_ff  <= '0;
         hist2_ff  <= '0;
         winpos_ff <= '0;
         okp_ff    <= 1'b0;
         rdyp_ff   <= 3'd0;
         okhit_ff  <= 1'b0;
         remain_ff <= '0;
         msgpos_ff <= '0;
         link_ff   <= 1'b0;
      end else if (byte_accept) begin
         hist0_ff  <= hist0_in;
         hist1_ff  <= hist1_in;
         hist2_ff  <= hist2_in;
         winpos_ff <= winpos_in;
         okp_ff    <= okp_in;
         rdyp_ff   <= rdyp_in;
         okhit_ff  <= okhit_in;
         remain_ff <= remain_in;
         msgpos_ff <= msgpos_in;
         link_ff   <= link_in;
      end
   end

   // Window position never reaches the window length
   assert property (@(posedge clock) disable iff (reset)
      winpos_ff < WinPosW'(WINDOW))
      else $error("window position out of range");

   // Ready tracker stays within the text length
   assert property (@(posedge clock) disable iff (reset)
      rdyp_ff <= ReadyFull)
      else $error("ready tracker out of range");

   // A pending hit in the window is reported by the next command-mode byte
   assert property (@(posedge clock) disable iff (reset)
      byte_accept && command_mode && okhit_ff |-> result.reply_seen)
      else $error("pending reply not reported");

endmodule
